### design/hcl_pkg.sv
package hcl_pkg;

  // default length of one field buffer; a field holds up to FIELD_LEN-1 bytes
  localparam int FIELD_LEN_DEF = 32;

  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 16;
  localparam int PARAM_W = 32;
  localparam int LEN_W   = 5;

  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
  localparam logic [BYTE_W-1:0] CH_9     = 8'h39;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CODE1,
    PH_CODE2,
    PH_SEP,
    PH_PARAM,
    PH_VALUE,
    PH_LF
  } phase_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_ISSUE,
    EM_HOLD
  } emit_state_t;

endpackage

### design/hcl_in_if.sv
interface hcl_in_if;
  logic                       valid;
  logic                       ready;
  logic [hcl_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### design/hcl_out_if.sv
interface hcl_out_if;
  logic                        valid;
  logic                        ready;
  logic [hcl_pkg::BYTE_W-1:0]  src;
  logic [hcl_pkg::CODE_W-1:0]  command_code;
  logic [hcl_pkg::PARAM_W-1:0] parameter_res;
  logic [hcl_pkg::LEN_W-1:0]   value_length;
  logic [hcl_pkg::BYTE_W-1:0]  value_byte;
  logic [hcl_pkg::LEN_W-1:0]   byte_position;
  logic                        last;

  modport source (output valid, output src, output command_code, output parameter_res,
                  output value_length, output value_byte, output byte_position,
                  output last, input ready);
  modport sink (input valid, input src, input command_code, input parameter_res,
                input value_length, input value_byte, input byte_position,
                input last, output ready);
endinterface

### design/hcl_ram.sv
module hcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 31
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/hash_command_line_parser.sv
// hash command line parser
// in_if carries one received byte per beat; lines look like
// '#' c1 c2 [',' decimal [',' value text]] then CR LF or LF. a '#' restarts
// the line anywhere, bytes before the first '#' are dropped, and a bad or
// over-long line is dropped without any result.
// out_if gives one beat per value byte of a finished line (last on the final
// one), or a single beat with zero value fields when there is no value text.
// cfg_we / cfg_wdata write the source id copied into every result beat.
// while a line is being parsed one byte is taken every cycle. the byte that
// ends a line hands off to the emitter, which reads the value store (a ram
// with one read port and a registered read) one result beat at a time;
// in_if.ready stays low until the last result sits in the output register,
// so no new line is taken while a finished line is being emitted.
// the ending byte moves the emitter to issue, which registers the first
// result beat, or with value text reads the store and registers it in hold.
// a stalled receiver simply holds the output register and the emitter.
// reset (rst_n low, synchronous) returns to waiting for '#'; the value
// store is not cleared, since every entry read was written in that line.
module hash_command_line_parser #(
  parameter int FIELD_LEN = hcl_pkg::FIELD_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [hcl_pkg::BYTE_W-1:0] cfg_wdata,
  hcl_in_if.sink                     in_if,
  hcl_out_if.source                  out_if
);

  import hcl_pkg::*;

  // counters hold up to FIELD_LEN-1; store depth is FIELD_LEN-1
  localparam int CNT_W  = $clog2(FIELD_LEN);
  localparam int DEPTH  = FIELD_LEN - 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_W-1:0] FIELD_MAX = CNT_W'(FIELD_LEN - 1);

  // configuration
  logic [BYTE_W-1:0] source_id_r;

  // parser state
  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   field_count_r, field_count_nxt;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic [PARAM_W-1:0] param_acc_r, param_acc_nxt;
  logic               param_stopped_r, param_stopped_nxt;
  logic [CNT_W-1:0]   value_count_r, value_count_nxt;

  // emitter state
  emit_state_t        em_state_r, em_state_nxt;
  logic [CNT_W-1:0]   em_k_r, em_k_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [CODE_W-1:0]  out_code_r, out_code_nxt;
  logic [BYTE_W-1:0]  out_src_r, out_src_nxt;
  logic [PARAM_W-1:0] out_param_r, out_param_nxt;
  logic [LEN_W-1:0]   out_len_r, out_len_nxt;
  logic [BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic [LEN_W-1:0]   out_pos_r, out_pos_nxt;
  logic               out_last_r, out_last_nxt;

  // value store ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_re;
  logic [BYTE_W-1:0] ram_rdata;

  logic              in_fire;
  logic              done;
  logic              out_free;
  logic [BYTE_W-1:0] c;

  assign c        = in_if.rx_byte;
  // input is held off while a finished line is being emitted
  assign in_if.ready = (em_state_r == EM_IDLE);
  assign in_fire  = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;

  hcl_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_value_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (c),
    .re    (ram_re),
    .raddr (em_k_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  assign ram_waddr = field_count_r[ADDR_W-1:0];

  // parser: one byte per accepted beat
  always_comb begin
    phase_nxt         = phase_r;
    field_count_nxt   = field_count_r;
    code_nxt          = code_r;
    param_acc_nxt     = param_acc_r;
    param_stopped_nxt = param_stopped_r;
    value_count_nxt   = value_count_r;
    ram_we            = 1'b0;
    done              = 1'b0;

    if (in_fire) begin
      if (c == CH_HASH) begin
        // start of a new line, whatever came before
        phase_nxt         = PH_CODE1;
        field_count_nxt   = '0;
        code_nxt          = '0;
        param_acc_nxt     = '0;
        param_stopped_nxt = 1'b0;
        value_count_nxt   = '0;
      end else begin
        case (phase_r)
          PH_CODE1: begin
            code_nxt  = {8'h00, c};
            phase_nxt = PH_CODE2;
          end
          PH_CODE2: begin
            code_nxt  = {code_r[7:0], c};
            phase_nxt = PH_SEP;
          end
          PH_SEP: begin
            if (c == CH_COMMA) begin
              phase_nxt = PH_PARAM;
            end else if (c == CH_CR) begin
              phase_nxt = PH_LF;
            end else if (c == CH_LF) begin
              done = 1'b1;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_PARAM: begin
            if (c == CH_COMMA || c == CH_CR || c == CH_LF) begin
              field_count_nxt = '0;
              if (c == CH_COMMA) begin
                phase_nxt = PH_VALUE;
              end else if (c == CH_CR) begin
                phase_nxt = PH_LF;
              end else begin
                done = 1'b1;
              end
            end else if (field_count_r < FIELD_MAX) begin
              field_count_nxt = field_count_r + CNT_W'(1);
              if (!param_stopped_r) begin
                if (c inside {[CH_0:CH_9]}) begin
                  // acc*10 as two shifts and one add
                  param_acc_nxt = (param_acc_r << 3) + (param_acc_r << 1)
                                  + PARAM_W'(c[3:0]);
                end else begin
                  param_stopped_nxt = 1'b1;
                end
              end
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_VALUE: begin
            if (c == CH_CR || c == CH_LF) begin
              value_count_nxt = field_count_r;
              if (c == CH_CR) begin
                phase_nxt = PH_LF;
              end else begin
                done = 1'b1;
              end
            end else if (field_count_r < FIELD_MAX) begin
              ram_we          = 1'b1;
              field_count_nxt = field_count_r + CNT_W'(1);
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_LF: begin
            if (c == CH_LF) begin
              done = 1'b1;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
        if (done) begin
          phase_nxt = PH_IDLE;
        end
      end
    end
  end

  // emitter: read one value byte, then move it into the output register; a line without value text gets one beat
  always_comb begin
    em_state_nxt  = em_state_r;
    em_k_nxt      = em_k_r;
    ram_re        = 1'b0;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_src_nxt   = out_src_r;
    out_code_nxt  = out_code_r;
    out_param_nxt = out_param_r;
    out_len_nxt   = out_len_r;
    out_byte_nxt  = out_byte_r;
    out_pos_nxt   = out_pos_r;
    out_last_nxt  = out_last_r;

    case (em_state_r)
      EM_IDLE: begin
        if (done) begin
          em_state_nxt = EM_ISSUE;
          em_k_nxt     = '0;
        end
      end
      EM_ISSUE: begin
        if (value_count_r == '0) begin
          // no value text: one beat with zero value fields
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_src_nxt   = source_id_r;
            out_code_nxt  = code_r;
            out_param_nxt = param_acc_r;
            out_len_nxt   = '0;
            out_byte_nxt  = '0;
            out_pos_nxt   = '0;
            out_last_nxt  = 1'b1;
            em_state_nxt  = EM_IDLE;
          end
        end else begin
          ram_re       = 1'b1;
          em_state_nxt = EM_HOLD;
        end
      end
      EM_HOLD: begin
        // read data is held until the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_src_nxt   = source_id_r;
          out_code_nxt  = code_r;
          out_param_nxt = param_acc_r;
          out_len_nxt   = LEN_W'(value_count_r);
          out_byte_nxt  = ram_rdata;
          out_pos_nxt   = LEN_W'(em_k_r);
          out_last_nxt  = (em_k_r + CNT_W'(1) == value_count_r);
          em_k_nxt      = em_k_r + CNT_W'(1);
          em_state_nxt  = (em_k_r + CNT_W'(1) == value_count_r) ? EM_IDLE : EM_ISSUE;
        end
      end
      default: begin
        em_state_nxt = EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_id_r     <= '0;
      phase_r         <= PH_IDLE;
      field_count_r   <= '0;
      code_r          <= '0;
      param_acc_r     <= '0;
      param_stopped_r <= 1'b0;
      value_count_r   <= '0;
      em_state_r      <= EM_IDLE;
      em_k_r          <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        source_id_r <= cfg_wdata;
      end
      phase_r         <= phase_nxt;
      field_count_r   <= field_count_nxt;
      code_r          <= code_nxt;
      param_acc_r     <= param_acc_nxt;
      param_stopped_r <= param_stopped_nxt;
      value_count_r   <= value_count_nxt;
      em_state_r      <= em_state_nxt;
      em_k_r          <= em_k_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    out_src_r   <= out_src_nxt;
    out_code_r  <= out_code_nxt;
    out_param_r <= out_param_nxt;
    out_len_r   <= out_len_nxt;
    out_byte_r  <= out_byte_nxt;
    out_pos_r   <= out_pos_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.src           = out_src_r;
  assign out_if.command_code  = out_code_r;
  assign out_if.parameter_res = out_param_r;
  assign out_if.value_length  = out_len_r;
  assign out_if.value_byte    = out_byte_r;
  assign out_if.byte_position = out_pos_r;
  assign out_if.last          = out_last_r;

endmodule

### sim/hash_command_line_parser_test.sv
`timescale 1ns / 1ps

module hash_command_line_parser_test;
  import hcl_pkg::*;

  // field buffers hold one byte less than their length
  localparam int FIELD_LEN = FIELD_LEN_DEF;
  localparam int FIELD_MAX = FIELD_LEN - 1;

  // idle cycles before a source id write, and after the last beat at the end
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 2 * FIELD_LEN + 8;

  // long receiver hold-off, and the number of cycles without any beat that ends the run
  localparam int HOLDOFF_CYCLES = 250;
  localparam int STALL_LIMIT    = 3000;

  typedef logic [BYTE_W-1:0] rx_bytes_t[$];

  // one expected result beat
  typedef struct packed {
    logic [BYTE_W-1:0]  source;
    logic [CODE_W-1:0]  code;
    logic [PARAM_W-1:0] param;
    logic [LEN_W-1:0]   vlen;
    logic [BYTE_W-1:0]  vbyte;
    logic [LEN_W-1:0]   vpos;
    logic               last;
  } cmd_beat_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [BYTE_W-1:0] cfg_wdata;

  hcl_in_if  in_ch ();
  hcl_out_if out_ch ();

  hash_command_line_parser #(
    .FIELD_LEN(FIELD_LEN)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  // line parser state as the testbench tracks it
  phase_t             line_phase;
  int unsigned        field_fill;
  logic [CODE_W-1:0]  code_acc;
  logic [PARAM_W-1:0] param_acc;
  bit                 param_halted;
  logic [BYTE_W-1:0]  value_mem [FIELD_MAX];
  int unsigned        value_len;
  logic [BYTE_W-1:0]  source_id_now;

  // result beats still owed by the block, oldest first
  cmd_beat_t expected_beats[$];

  int errors        = 0;
  int bytes_taken   = 0;
  int beats_checked = 0;
  int source_writes = 0;

  // traffic shaping: no_idle for the sender and the receiver, hold_out_cycles for the receiver
  bit no_idle         = 1'b0;
  int hold_out_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // gap length for either side: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random byte that is never a hash; commas and line ends only if allowed
  function automatic logic [BYTE_W-1:0] other_byte(input bit allow_comma, input bit allow_eol);
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255));
    while (b == CH_HASH || (!allow_comma && b == CH_COMMA) ||
           (!allow_eol && (b == CH_CR || b == CH_LF)));
    return b;
  endfunction

  // tracks one accepted byte through the line grammar and queues the beats of a finished line
  function automatic void track_line_byte(input logic [BYTE_W-1:0] c);
    bit        line_done;
    cmd_beat_t beat;
    line_done = 1'b0;
    if (c == CH_HASH) begin
      // a hash starts a fresh line from any phase
      line_phase   = PH_CODE1;
      field_fill   = 0;
      code_acc     = '0;
      param_acc    = '0;
      param_halted = 1'b0;
      value_len    = 0;
    end else begin
      case (line_phase)
        PH_CODE1: begin
          // any byte is a code character, line ends included
          code_acc   = {8'h00, c};
          line_phase = PH_CODE2;
        end
        PH_CODE2: begin
          code_acc   = {code_acc[BYTE_W-1:0], c};
          line_phase = PH_SEP;
        end
        PH_SEP: begin
          if (c == CH_COMMA) line_phase = PH_PARAM;
          else if (c == CH_CR) line_phase = PH_LF;
          else if (c == CH_LF) line_done = 1'b1;
          else line_phase = PH_IDLE;
        end
        PH_PARAM: begin
          if (c == CH_COMMA || c == CH_CR || c == CH_LF) begin
            field_fill = 0;
            if (c == CH_COMMA) line_phase = PH_VALUE;
            else if (c == CH_CR) line_phase = PH_LF;
            else line_done = 1'b1;
          end else if (field_fill < FIELD_MAX) begin
            field_fill++;
            // the first non-digit freezes the number, the field runs on
            if (!param_halted) begin
              if (c >= CH_0 && c <= CH_9) param_acc = param_acc * 32'd10 + 32'(c - CH_0);
              else param_halted = 1'b1;
            end
          end else begin
            line_phase = PH_IDLE;
          end
        end
        PH_VALUE: begin
          // commas are plain text here
          if (c == CH_CR || c == CH_LF) begin
            value_len = field_fill;
            if (c == CH_CR) line_phase = PH_LF;
            else line_done = 1'b1;
          end else if (field_fill < FIELD_MAX) begin
            value_mem[field_fill] = c;
            field_fill++;
          end else begin
            line_phase = PH_IDLE;
          end
        end
        PH_LF: begin
          if (c == CH_LF) line_done = 1'b1;
          else line_phase = PH_IDLE;
        end
        default: line_phase = PH_IDLE;
      endcase
    end

    if (line_done) begin
      beat.source = source_id_now;
      beat.code   = code_acc;
      beat.param  = param_acc;
      if (value_len == 0) begin
        // no value text: a single beat with zero value fields
        beat.vlen  = '0;
        beat.vbyte = '0;
        beat.vpos  = '0;
        beat.last  = 1'b1;
        expected_beats.push_back(beat);
      end else begin
        for (int k = 0; k < value_len; k++) begin
          beat.vlen  = LEN_W'(value_len);
          beat.vbyte = value_mem[k];
          beat.vpos  = LEN_W'(k);
          beat.last  = (k + 1 == value_len);
          expected_beats.push_back(beat);
        end
      end
      line_phase = PH_IDLE;
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // one process watches both channels: result beats are checked, input beats predicted
  always @(posedge clk) begin : beat_monitor
    cmd_beat_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        beats_checked++;
        if (expected_beats.size() == 0) begin
          errors++;
          $display("%0t: result beat with none expected, expected nothing, got code %0h",
                   $time, out_ch.command_code);
        end else begin
          want = expected_beats.pop_front();
          check_field("source", 32'(want.source), 32'(out_ch.src));
          check_field("command_code", 32'(want.code), 32'(out_ch.command_code));
          check_field("parameter_res", want.param, out_ch.parameter_res);
          check_field("value_length", 32'(want.vlen), 32'(out_ch.value_length));
          check_field("value_byte", 32'(want.vbyte), 32'(out_ch.value_byte));
          check_field("byte_position", 32'(want.vpos), 32'(out_ch.byte_position));
          check_field("last", 32'(want.last), 32'(out_ch.last));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        bytes_taken++;
        track_line_byte(in_ch.rx_byte);
      end
    end
  end

  // receiver: random ready gaps, plus a long hold-off when a test asks for one
  initial begin : result_sink
    int gap;
    int hold;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_out_cycles > 0) begin
        hold            = hold_out_cycles;
        hold_out_cycles = 0;
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // ends the run when no beat moves on either channel for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
    $display("hash_command_line_parser_test: done, errors");
    $finish;
  end

  // offers one byte after a random gap and returns at the edge that takes it
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_bytes(input rx_bytes_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // stop offering, wait for every owed beat, then let the block settle
  task automatic pause_until_drained(input int extra);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // only called with the input idle and nothing owed
  task automatic write_source_id(input logic [BYTE_W-1:0] id);
    cfg_we    <= 1'b1;
    cfg_wdata <= id;
    @(posedge clk);
    cfg_we <= 1'b0;
    source_id_now = id;
    source_writes++;
  endtask

  // line with random code, optional parameter and value text; well-formed but for a rare value overflow
  function automatic rx_bytes_t random_line(input bit with_value);
    rx_bytes_t q;
    int        form;
    int        n;
    q.push_back(CH_HASH);
    repeat (2) begin
      q.push_back(($urandom_range(0, 3) != 0) ? BYTE_W'("A" + $urandom_range(0, 25))
                                              : other_byte(1, 1));
    end
    form = with_value ? 2 : $urandom_range(0, 2);
    if (form >= 1) begin
      q.push_back(CH_COMMA);
      // mostly short numbers, sometimes long enough to wrap
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, FIELD_MAX) : $urandom_range(0, 5);
      repeat (n) begin
        q.push_back(($urandom_range(0, 9) != 0) ? BYTE_W'(CH_0 + $urandom_range(0, 9))
                                                : other_byte(0, 0));
      end
    end
    if (form == 2) begin
      q.push_back(CH_COMMA);
      // a rare length of FIELD_LEN overflows the value buffer
      if (with_value) n = $urandom_range(3, 8);
      else n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, FIELD_LEN) : $urandom_range(0, 5);
      repeat (n) q.push_back(other_byte(1, 0));
    end
    if ($urandom_range(0, 1)) q.push_back(CH_CR);
    q.push_back(CH_LF);
    return q;
  endfunction

  // broken line: stray byte inserted, wrong terminator, or cut short
  function automatic rx_bytes_t damage_line(input rx_bytes_t q);
    logic [BYTE_W-1:0] b;
    int                cut;
    b = BYTE_W'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0: q.insert($urandom_range(1, q.size() - 1), b);
      1: q[q.size() - 1] = (b == CH_LF) ? CH_CR : b;
      default: begin
        cut = $urandom_range(1, q.size() - 2);
        while (q.size() > cut) void'(q.pop_back());
      end
    endcase
    return q;
  endfunction

  // short fixed lines for the grammar corners, source id still at its reset value
  task automatic test_directed_lines();
    rx_bytes_t q;
    q = '{
      8'hFF,                                            // no hash yet, ignored
      CH_HASH, CH_CR, CH_LF, CH_LF,                     // cr and lf taken as code characters
      CH_HASH, 8'h00, CH_HASH, 8'h00, 8'hFF, CH_COMMA,  // hash restarts inside the code
      "7", "x", "9", CH_COMMA, 8'hFF, CH_COMMA,         // number stops at x, comma in value
      CH_CR, CH_LF,
      CH_HASH, "C", "D", "?",                           // bad byte after the code drops it
      CH_HASH, "E", "F", CH_CR, "Z"                     // cr without lf drops it
    };
    send_bytes(q);
    pause_until_drained(SETTLE_CYCLES);
  endtask

  // full-length fields, and one byte too many in each field
  task automatic test_field_limits();
    rx_bytes_t q;
    write_source_id(8'hFF);

    // 31 digits wrap the number, 31 value bytes give the longest result burst
    q = '{CH_HASH, "L", "M", CH_COMMA};
    repeat (FIELD_MAX) q.push_back(BYTE_W'(CH_0 + $urandom_range(0, 9)));
    q.push_back(CH_COMMA);
    repeat (FIELD_MAX) q.push_back(other_byte(1, 0));
    q.push_back(CH_CR);
    q.push_back(CH_LF);
    send_bytes(q);

    // parameter overflow, the trailing lf must not complete anything
    q = '{CH_HASH, "N", "P", CH_COMMA};
    repeat (FIELD_LEN) q.push_back(BYTE_W'(CH_0 + $urandom_range(0, 9)));
    q.push_back(CH_LF);
    send_bytes(q);

    // value overflow
    q = '{CH_HASH, "Q", "R", CH_COMMA, CH_COMMA};
    repeat (FIELD_LEN) q.push_back(other_byte(1, 0));
    q.push_back(CH_LF);
    send_bytes(q);

    pause_until_drained(SETTLE_CYCLES);
  endtask

  // mostly good lines with random content, some broken lines and line noise
  task automatic test_random_traffic();
    rx_bytes_t q;
    int        sent;
    for (int seg = 0; seg < 3; seg++) begin
      write_source_id(BYTE_W'($urandom_range(1, 254)));
      // middle segment runs back to back on both sides
      no_idle = (seg == 1);
      sent    = 0;
      while (sent < 12) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(0, 255)));
        end
        q = random_line(1'b0);
        if ($urandom_range(0, 9) == 0) q = damage_line(q);
        send_bytes(q);
        sent += q.size();
      end
      no_idle = 1'b0;
      pause_until_drained(SETTLE_CYCLES);
    end
  endtask

  // receiver holds off while lines with value text keep coming, so the input stalls
  task automatic test_output_holdoff();
    write_source_id(8'h00);
    hold_out_cycles = HOLDOFF_CYCLES;
    // the receiver clears the request once its hold-off has started
    while (hold_out_cycles != 0) @(posedge clk);
    repeat (3) send_bytes(random_line(1'b1));
    pause_until_drained(SETTLE_CYCLES);
  endtask

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    line_phase    = PH_IDLE;
    source_id_now = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_lines();
    test_field_limits();
    test_random_traffic();
    test_output_holdoff();

    // nothing owed, then a quiet tail to catch stray beats
    pause_until_drained(TAIL_CYCLES);

    $display("hash_command_line_parser_test: %0d bytes taken, %0d result beats checked,",
             bytes_taken, beats_checked);
    $display("  %0d source id writes; grammar corners, full and overflowing fields,",
             source_writes);
    $display("  broken lines, idle and stalled channels");
    if (errors == 0) begin
      $display("hash_command_line_parser_test: done, clean");
    end else begin
      $display("hash_command_line_parser_test: done, errors");
    end
    $finish;
  end

endmodule
